[rtl/i2c_register_access_master_assert.svh]
// ---------------------------------------------------------------------------
// i2c_register_access_master_assert.svh
// Assertion macros shared by the I2C register access master.
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// Property that must hold on every clock edge out of reset.
`define I2CRAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define I2CRAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2cram_pkg.sv]
// ---------------------------------------------------------------------------
// i2cram_pkg
// Types and constants shared by the I2C register access master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cram_pkg;

  // APB register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_DEVICE_ADDR = 1'b0;   // word index of device_address

  // Command codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Completion status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NACK_DEVW = 3'd1;
  localparam logic [2:0] ST_NACK_REG = 3'd2;
  localparam logic [2:0] ST_NACK_DATA = 3'd3;
  localparam logic [2:0] ST_NACK_DEVR = 3'd4;

  // One bus tick item
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // Pin levels and transfer status after one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [2:0] status;
    logic [7:0] read_value;
  } result_t;

endpackage

[rtl/i2cram_cfg.sv]
// ---------------------------------------------------------------------------
// i2cram_cfg
// APB configuration register holding the seven-bit device address.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cram_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cram_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [i2cram_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i2cram_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready,
  output logic [6:0]                         dev_addr_o
);

  logic [6:0] dev_addr_q, dev_addr_d;
  logic       wr_en;
  logic       sel_dev;

  assign pready  = 1'b1;
  assign sel_dev = (paddr[2] == i2cram_pkg::REG_DEVICE_ADDR);
  assign wr_en   = psel && penable && pwrite && sel_dev;

  // register write
  always_comb begin
    dev_addr_d = dev_addr_q;
    if (wr_en) begin
      dev_addr_d = pwdata[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 7'd0;
    end else begin
      dev_addr_q <= dev_addr_d;
    end
  end

  // read back
  assign prdata     = sel_dev ? {{(i2cram_pkg::APB_DATA_W-7){1'b0}}, dev_addr_q}
                              : '0;
  assign dev_addr_o = dev_addr_q;

endmodule

[rtl/i2cram_seq.sv]
// ---------------------------------------------------------------------------
// i2cram_seq
// Bus sequencer: moves the I2C pins one step per tick and tracks the
// acknowledge status of the register transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cram_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  i2cram_pkg::item_t     item_i,
  input  logic [6:0]            dev_addr_i,
  output i2cram_pkg::result_t   result_o
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_DW0  = 5'd3,
    PH_DW1  = 5'd4,
    PH_DW2  = 5'd5,
    PH_RG0  = 5'd6,
    PH_RG1  = 5'd7,
    PH_RG2  = 5'd8,
    PH_DT0  = 5'd9,
    PH_DT1  = 5'd10,
    PH_DT2  = 5'd11,
    PH_RS1  = 5'd12,
    PH_RS2  = 5'd13,
    PH_RS3  = 5'd14,
    PH_RS4  = 5'd15,
    PH_DR0  = 5'd16,
    PH_DR1  = 5'd17,
    PH_DR2  = 5'd18,
    PH_RD0  = 5'd19,
    PH_RD1  = 5'd20,
    PH_RD2  = 5'd21,
    PH_SP1  = 5'd22,
    PH_SP2  = 5'd23,
    PH_SP3  = 5'd24
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       kind_q, kind_d;       // 1: read
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic [2:0] status_q, status_d;
  logic       scl_q, scl_d;
  logic       sdl_q, sdl_d;
  logic       sdd_q, sdd_d;
  logic       done;

  // byte send decode: step within the bit and phase group
  phase_e     snd_ph0, snd_ph1, snd_ph2;
  logic [1:0] snd_sub;
  logic [2:0] snd_code;

  always_comb begin
    snd_ph0  = PH_IDLE;
    snd_sub  = 2'd0;
    snd_code = i2cram_pkg::ST_OK;
    case (phase_q)
      PH_DW0, PH_DW1, PH_DW2: begin
        snd_ph0  = PH_DW0;
        snd_code = i2cram_pkg::ST_NACK_DEVW;
      end
      PH_RG0, PH_RG1, PH_RG2: begin
        snd_ph0  = PH_RG0;
        snd_code = i2cram_pkg::ST_NACK_REG;
      end
      PH_DT0, PH_DT1, PH_DT2: begin
        snd_ph0  = PH_DT0;
        snd_code = i2cram_pkg::ST_NACK_DATA;
      end
      PH_DR0, PH_DR1, PH_DR2: begin
        snd_ph0  = PH_DR0;
        snd_code = i2cram_pkg::ST_NACK_DEVR;
      end
      default: begin
        snd_ph0 = PH_IDLE;
      end
    endcase
    case (phase_q)
      PH_DW1, PH_RG1, PH_DT1, PH_DR1: snd_sub = 2'd1;
      PH_DW2, PH_RG2, PH_DT2, PH_DR2: snd_sub = 2'd2;
      default:                        snd_sub = 2'd0;
    endcase
  end

  always_comb begin
    case (snd_ph0)
      PH_DW0:  begin snd_ph1 = PH_DW1; snd_ph2 = PH_DW2; end
      PH_RG0:  begin snd_ph1 = PH_RG1; snd_ph2 = PH_RG2; end
      PH_DT0:  begin snd_ph1 = PH_DT1; snd_ph2 = PH_DT2; end
      PH_DR0:  begin snd_ph1 = PH_DR1; snd_ph2 = PH_DR2; end
      default: begin snd_ph1 = PH_IDLE; snd_ph2 = PH_IDLE; end
    endcase
  end

  // next-state logic for one tick
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    kind_d   = kind_q;
    reg_d    = reg_q;
    data_d   = data_q;
    status_d = status_q;
    scl_d    = scl_q;
    sdl_d    = sdl_q;
    sdd_d    = sdd_q;
    done     = 1'b0;

    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          scl_d = 1'b1;
          sdl_d = 1'b1;
          if (item_i.operation == i2cram_pkg::OP_WRITE ||
              item_i.operation == i2cram_pkg::OP_READ) begin
            kind_d   = (item_i.operation == i2cram_pkg::OP_READ);
            reg_d    = item_i.register_address;
            data_d   = item_i.write_data;
            status_d = i2cram_pkg::ST_OK;
            shift_d  = 8'd0;
            cnt_d    = 4'd0;
            sdd_d    = 1'b1;
            phase_d  = PH_ST1;
          end else begin
            sdd_d = 1'b0;
          end
        end
        // start condition
        PH_ST1: begin
          sdl_d   = 1'b0;
          sdd_d   = 1'b1;
          phase_d = PH_ST2;
        end
        PH_ST2: begin
          scl_d   = 1'b0;
          shift_d = {dev_addr_i, 1'b0};
          cnt_d   = 4'd0;
          phase_d = PH_DW0;
        end
        // byte send with ack check on the slave acknowledge clock
        PH_DW0, PH_DW1, PH_DW2, PH_RG0, PH_RG1, PH_RG2,
        PH_DT0, PH_DT1, PH_DT2, PH_DR0, PH_DR1, PH_DR2: begin
          if (snd_sub == 2'd0) begin
            scl_d = 1'b0;
            if (!cnt_q[3]) begin
              sdd_d = 1'b1;
              sdl_d = shift_q[7];
            end else begin
              sdd_d = 1'b0;
              sdl_d = 1'b1;
            end
            phase_d = snd_ph1;
          end else if (snd_sub == 2'd1) begin
            scl_d = 1'b1;
            if (cnt_q[3] && item_i.sda_in) begin
              status_d = snd_code;
            end
            phase_d = snd_ph2;
          end else begin
            scl_d = 1'b0;
            if (!cnt_q[3]) begin
              shift_d = {shift_q[6:0], 1'b0};
              cnt_d   = cnt_q + 4'd1;
              phase_d = snd_ph0;
            end else if (status_q != i2cram_pkg::ST_OK) begin
              phase_d = PH_SP1;
            end else if (snd_ph0 == PH_DW0) begin
              shift_d = reg_q;
              cnt_d   = 4'd0;
              phase_d = PH_RG0;
            end else if (snd_ph0 == PH_RG0) begin
              if (!kind_q) begin
                shift_d = data_q;
                cnt_d   = 4'd0;
                phase_d = PH_DT0;
              end else begin
                phase_d = PH_RS1;
              end
            end else if (snd_ph0 == PH_DT0) begin
              phase_d = PH_SP1;
            end else begin
              shift_d = 8'd0;
              cnt_d   = 4'd0;
              phase_d = PH_RD0;
            end
          end
        end
        // repeated start
        PH_RS1: begin
          scl_d   = 1'b0;
          sdl_d   = 1'b1;
          sdd_d   = 1'b1;
          phase_d = PH_RS2;
        end
        PH_RS2: begin
          scl_d   = 1'b1;
          phase_d = PH_RS3;
        end
        PH_RS3: begin
          sdl_d   = 1'b0;
          sdd_d   = 1'b1;
          phase_d = PH_RS4;
        end
        PH_RS4: begin
          scl_d   = 1'b0;
          shift_d = {dev_addr_i, 1'b1};
          cnt_d   = 4'd0;
          phase_d = PH_DR0;
        end
        // read byte, then master NACK clock
        PH_RD0: begin
          scl_d   = 1'b0;
          sdl_d   = 1'b1;
          sdd_d   = cnt_q[3];
          phase_d = PH_RD1;
        end
        PH_RD1: begin
          scl_d = 1'b1;
          if (!cnt_q[3]) begin
            shift_d = {shift_q[6:0], item_i.sda_in};
          end
          phase_d = PH_RD2;
        end
        PH_RD2: begin
          scl_d = 1'b0;
          if (!cnt_q[3]) begin
            cnt_d   = cnt_q + 4'd1;
            phase_d = PH_RD0;
          end else begin
            phase_d = PH_SP1;
          end
        end
        // stop condition
        PH_SP1: begin
          scl_d   = 1'b0;
          sdl_d   = 1'b0;
          sdd_d   = 1'b1;
          phase_d = PH_SP2;
        end
        PH_SP2: begin
          scl_d   = 1'b1;
          phase_d = PH_SP3;
        end
        PH_SP3: begin
          sdl_d   = 1'b1;
          sdd_d   = 1'b0;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          scl_d   = 1'b1;
          sdl_d   = 1'b1;
          sdd_d   = 1'b0;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= 4'd0;
      shift_q  <= 8'd0;
      kind_q   <= 1'b0;
      reg_q    <= 8'd0;
      data_q   <= 8'd0;
      status_q <= i2cram_pkg::ST_OK;
      scl_q    <= 1'b1;
      sdl_q    <= 1'b1;
      sdd_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      kind_q   <= kind_d;
      reg_q    <= reg_d;
      data_q   <= data_d;
      status_q <= status_d;
      scl_q    <= scl_d;
      sdl_q    <= sdl_d;
      sdd_q    <= sdd_d;
    end
  end

  // result of this tick
  always_comb begin
    result_o.scl_level  = scl_d;
    result_o.sda_level  = sdl_d;
    result_o.sda_drive  = sdd_d;
    result_o.busy       = (phase_d != PH_IDLE);
    result_o.done       = done;
    result_o.status     = done ? status_d : i2cram_pkg::ST_OK;
    result_o.read_value = (done && kind_d && status_d == i2cram_pkg::ST_OK) ? shift_d
                                                                             : 8'd0;
  end

endmodule

[rtl/i2c_register_access_master.sv]
// ---------------------------------------------------------------------------
// i2c_register_access_master
// Tick-driven I2C master for single-byte register write and read on one
// device, with an APB register for the device address.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_stall_o    operation, register_address,
//                                                  write_data, sda_in
//  out       output     out_valid_o / out_stall_i  scl/sda levels, sda_drive,
//                                                  busy, done, status, read_value
//  cfg       input      APB psel/penable/pready    device_address at 0x0
//
//  Each tick passes the input register, then the sequencer step into the result
//  register. One tick per cycle sustained while the result side does not stall.
//  The sequencer state loop (phase, bit counter, shift byte) is one step per tick.
//  Reset leaves SCL high, SDA released and the sequencer idle.
//  A stalled result holds; the input register still takes one more tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "i2c_register_access_master_assert.svh"

module i2c_register_access_master (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [7:0]                         register_address_i,
  input  logic [7:0]                         write_data_i,
  input  logic                               sda_in_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               scl_level_o,
  output logic                               sda_level_o,
  output logic                               sda_drive_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [2:0]                         status_o,
  output logic [7:0]                         read_value_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2cram_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [i2cram_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i2cram_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready
);

  logic                 in_vld_q, in_vld_d;
  i2cram_pkg::item_t    item_q, item_d;
  logic                 out_vld_q, out_vld_d;
  i2cram_pkg::result_t  res_q, res_d;
  i2cram_pkg::result_t  seq_res;
  logic [6:0]           dev_addr;
  logic                 in_load;
  logic                 advance;

  i2cram_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .dev_addr_o (dev_addr)
  );

  i2cram_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (item_q),
    .dev_addr_i (dev_addr),
    .result_o   (seq_res)
  );

  // handshake: step when the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  // input register
  always_comb begin
    in_vld_d = in_vld_q;
    item_d   = item_q;
    if (in_load) begin
      in_vld_d                = 1'b1;
      item_d.operation        = operation_i;
      item_d.register_address = register_address_i;
      item_d.write_data       = write_data_i;
      item_d.sda_in           = sda_in_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (advance) begin
      out_vld_d = 1'b1;
      res_d     = seq_res;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o  = out_vld_q;
  assign scl_level_o  = res_q.scl_level;
  assign sda_level_o  = res_q.sda_level;
  assign sda_drive_o  = res_q.sda_drive;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign status_o     = res_q.status;
  assign read_value_o = res_q.read_value;

  // checks
  `I2CRAM_ASSERT(a_done_not_busy, out_valid_o && done_res_o |-> !busy_res_o, "done while busy")
  `I2CRAM_ASSERT(a_status_on_done, out_valid_o && status_o != i2cram_pkg::ST_OK |-> done_res_o, "status without done")
  `I2CRAM_ASSERT(a_released_high, out_valid_o && !sda_drive_o |-> sda_level_o, "released SDA not high")
  `I2CRAM_ASSERT_NEXT(a_step_result, advance, out_valid_o, "stepped tick gave no result")

endmodule

[sim/i2c_register_access_master_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_register_access_master_tb
// Self-checking bench for the tick-driven I2C register access master. Every
// accepted tick is run through a cycle-true copy of the bus sequencer, and
// each returned pin/status word is compared with the oldest prediction.
// Random writes and reads, mostly acknowledged, run in six phases of one device
// address each, with random gaps, a long result hold-off and a burst phase.
// ---------------------------------------------------------------------------
module i2c_register_access_master_tb;

  // Unused command code, handled as a plain tick
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Sequencer phase codes
  localparam logic [4:0] SEQ_IDLE    = 5'd0;
  localparam logic [4:0] SEQ_START_A = 5'd1;
  localparam logic [4:0] SEQ_START_B = 5'd2;
  localparam logic [4:0] SEQ_DEVW    = 5'd3;
  localparam logic [4:0] SEQ_REG     = 5'd6;
  localparam logic [4:0] SEQ_DATA    = 5'd9;
  localparam logic [4:0] SEQ_RS_A    = 5'd12;
  localparam logic [4:0] SEQ_RS_B    = 5'd13;
  localparam logic [4:0] SEQ_RS_C    = 5'd14;
  localparam logic [4:0] SEQ_RS_D    = 5'd15;
  localparam logic [4:0] SEQ_DEVR    = 5'd16;
  localparam logic [4:0] SEQ_RDATA   = 5'd19;
  localparam logic [4:0] SEQ_STOP_A  = 5'd22;
  localparam logic [4:0] SEQ_STOP_B  = 5'd23;
  localparam logic [4:0] SEQ_STOP_C  = 5'd24;

  localparam logic [i2cram_pkg::APB_ADDR_W-1:0] DEV_ADDR_OFS =
    {i2cram_pkg::REG_DEVICE_ADDR, 2'b00};

  localparam int unsigned PHASE_TICKS = 235;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned QUIET_LIMIT = 3000;

  // -------------------------------------------------------------------------
  // Bus sequencer copy and result checker
  // -------------------------------------------------------------------------
  class tick_scoreboard;
    logic [6:0]          dev_addr;
    logic [4:0]          seq;
    logic [3:0]          bit_cnt;
    logic [7:0]          shreg;
    logic                is_read;
    logic [7:0]          reg_idx;
    logic [7:0]          wr_byte;
    logic [2:0]          xfer_status;
    logic                scl_q;
    logic                sda_q;
    logic                drive_q;
    i2cram_pkg::result_t pending_pin_states[$];
    int unsigned         mismatches;
    int unsigned         ticks_noted;
    int unsigned         results_checked;
    int unsigned         done_by_status[5];

    function void reset_state();
      dev_addr    = 7'd0;
      seq         = SEQ_IDLE;
      bit_cnt     = 4'd0;
      shreg       = 8'h00;
      is_read     = 1'b0;
      reg_idx     = 8'h00;
      wr_byte     = 8'h00;
      xfer_status = i2cram_pkg::ST_OK;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      drive_q     = 1'b0;
    endfunction

    function void load_byte(logic [7:0] value, logic [4:0] next_seq);
      shreg   = value;
      bit_cnt = 4'd0;
      seq     = next_seq;
    endfunction

    // one step of a sent byte: eight data bits, then the slave ack clock
    function void shift_out(logic [4:0] base, logic [2:0] code, logic sda);
      logic [4:0] offset;
      offset = seq - base;
      if (offset == 5'd0) begin
        scl_q = 1'b0;
        if (bit_cnt < 4'd8) begin
          drive_q = 1'b1;
          sda_q   = shreg[7];
        end else begin
          drive_q = 1'b0;
          sda_q   = 1'b1;
        end
        seq = base + 5'd1;
      end else if (offset == 5'd1) begin
        scl_q = 1'b1;
        if (bit_cnt >= 4'd8 && sda) xfer_status = code;
        seq = base + 5'd2;
      end else begin
        scl_q = 1'b0;
        if (bit_cnt < 4'd8) begin
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          seq     = base;
        end else if (xfer_status != i2cram_pkg::ST_OK) begin
          seq = SEQ_STOP_A;
        end else if (base == SEQ_DEVW) begin
          load_byte(reg_idx, SEQ_REG);
        end else if (base == SEQ_REG) begin
          if (!is_read) load_byte(wr_byte, SEQ_DATA);
          else seq = SEQ_RS_A;
        end else if (base == SEQ_DATA) begin
          seq = SEQ_STOP_A;
        end else begin
          load_byte(8'h00, SEQ_RDATA);
        end
      end
    endfunction

    function i2cram_pkg::result_t step_sequencer(i2cram_pkg::item_t it);
      i2cram_pkg::result_t r;
      logic                done;
      done = 1'b0;
      case (seq)
        SEQ_IDLE: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          if (it.operation == i2cram_pkg::OP_WRITE || it.operation == i2cram_pkg::OP_READ) begin
            is_read     = (it.operation == i2cram_pkg::OP_READ);
            reg_idx     = it.register_address;
            wr_byte     = it.write_data;
            xfer_status = i2cram_pkg::ST_OK;
            shreg       = 8'h00;
            bit_cnt     = 4'd0;
            drive_q     = 1'b1;
            seq         = SEQ_START_A;
          end else begin
            drive_q = 1'b0;
          end
        end
        SEQ_START_A: begin
          sda_q   = 1'b0;
          drive_q = 1'b1;
          seq     = SEQ_START_B;
        end
        SEQ_START_B: begin
          scl_q = 1'b0;
          load_byte({dev_addr, 1'b0}, SEQ_DEVW);
        end
        SEQ_DEVW, SEQ_DEVW + 5'd1, SEQ_DEVW + 5'd2:
          shift_out(SEQ_DEVW, i2cram_pkg::ST_NACK_DEVW, it.sda_in);
        SEQ_REG, SEQ_REG + 5'd1, SEQ_REG + 5'd2:
          shift_out(SEQ_REG, i2cram_pkg::ST_NACK_REG, it.sda_in);
        SEQ_DATA, SEQ_DATA + 5'd1, SEQ_DATA + 5'd2:
          shift_out(SEQ_DATA, i2cram_pkg::ST_NACK_DATA, it.sda_in);
        SEQ_DEVR, SEQ_DEVR + 5'd1, SEQ_DEVR + 5'd2:
          shift_out(SEQ_DEVR, i2cram_pkg::ST_NACK_DEVR, it.sda_in);
        // repeated start
        SEQ_RS_A: begin
          scl_q   = 1'b0;
          sda_q   = 1'b1;
          drive_q = 1'b1;
          seq     = SEQ_RS_B;
        end
        SEQ_RS_B: begin
          scl_q = 1'b1;
          seq   = SEQ_RS_C;
        end
        SEQ_RS_C: begin
          sda_q   = 1'b0;
          drive_q = 1'b1;
          seq     = SEQ_RS_D;
        end
        SEQ_RS_D: begin
          scl_q = 1'b0;
          load_byte({dev_addr, 1'b1}, SEQ_DEVR);
        end
        // read byte, then master NACK clock
        SEQ_RDATA: begin
          scl_q   = 1'b0;
          sda_q   = 1'b1;
          drive_q = (bit_cnt >= 4'd8);
          seq     = SEQ_RDATA + 5'd1;
        end
        SEQ_RDATA + 5'd1: begin
          scl_q = 1'b1;
          if (bit_cnt < 4'd8) shreg = {shreg[6:0], it.sda_in};
          seq = SEQ_RDATA + 5'd2;
        end
        SEQ_RDATA + 5'd2: begin
          scl_q = 1'b0;
          if (bit_cnt < 4'd8) begin
            bit_cnt = bit_cnt + 4'd1;
            seq     = SEQ_RDATA;
          end else begin
            seq = SEQ_STOP_A;
          end
        end
        // stop condition
        SEQ_STOP_A: begin
          scl_q   = 1'b0;
          sda_q   = 1'b0;
          drive_q = 1'b1;
          seq     = SEQ_STOP_B;
        end
        SEQ_STOP_B: begin
          scl_q = 1'b1;
          seq   = SEQ_STOP_C;
        end
        SEQ_STOP_C: begin
          sda_q   = 1'b1;
          drive_q = 1'b0;
          done    = 1'b1;
          seq     = SEQ_IDLE;
        end
        default: begin
          scl_q   = 1'b1;
          sda_q   = 1'b1;
          drive_q = 1'b0;
          seq     = SEQ_IDLE;
        end
      endcase
      r.scl_level  = scl_q;
      r.sda_level  = sda_q;
      r.sda_drive  = drive_q;
      r.busy       = (seq != SEQ_IDLE);
      r.done       = done;
      r.status     = done ? xfer_status : i2cram_pkg::ST_OK;
      r.read_value = (done && is_read && xfer_status == i2cram_pkg::ST_OK) ? shreg : 8'h00;
      return r;
    endfunction

    function void note_tick(i2cram_pkg::item_t it);
      pending_pin_states.push_back(step_sequencer(it));
      ticks_noted++;
    endfunction

    function bit idle();
      return seq == SEQ_IDLE;
    endfunction

    // next tick samples a slave acknowledge
    function bit ack_next();
      return bit_cnt >= 4'd8 &&
             (seq == SEQ_DEVW + 5'd1 || seq == SEQ_REG + 5'd1 ||
              seq == SEQ_DATA + 5'd1 || seq == SEQ_DEVR + 5'd1);
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(i2cram_pkg::result_t got);
      i2cram_pkg::result_t want;
      if (pending_pin_states.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_pin_states.pop_front();
        compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
        compare_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
        compare_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
        compare_field("busy", 8'(got.busy), 8'(want.busy));
        compare_field("done", 8'(got.done), 8'(want.done));
        compare_field("status", 8'(got.status), 8'(want.status));
        compare_field("read_value", got.read_value, want.read_value);
        if (want.done) done_by_status[want.status]++;
        results_checked++;
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Signals and DUT
  // -------------------------------------------------------------------------
  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [1:0]                        operation_i;
  logic [7:0]                        register_address_i;
  logic [7:0]                        write_data_i;
  logic                              sda_in_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              scl_level_o;
  logic                              sda_level_o;
  logic                              sda_drive_o;
  logic                              busy_res_o;
  logic                              done_res_o;
  logic [2:0]                        status_o;
  logic [7:0]                        read_value_o;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [i2cram_pkg::APB_ADDR_W-1:0] paddr;
  logic [i2cram_pkg::APB_DATA_W-1:0] pwdata;
  logic [i2cram_pkg::APB_DATA_W-1:0] prdata;
  logic                              pready;

  tick_scoreboard sb;
  bit             no_idle = 1'b0;
  int unsigned    quiet_cycles = 0;

  i2c_register_access_master u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .register_address_i (register_address_i),
    .write_data_i       (write_data_i),
    .sda_in_i           (sda_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .scl_level_o        (scl_level_o),
    .sda_level_o        (sda_level_o),
    .sda_drive_o        (sda_drive_o),
    .busy_res_o         (busy_res_o),
    .done_res_o         (done_res_o),
    .status_o           (status_o),
    .read_value_o       (read_value_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  function automatic i2cram_pkg::item_t tick_item(logic [1:0] op, logic [7:0] ra,
                                                  logic [7:0] wd, logic sda);
    i2cram_pkg::item_t it;
    it.operation        = op;
    it.register_address = ra;
    it.write_data       = wd;
    it.sda_in           = sda;
    return it;
  endfunction

  // Random tick shaped by where the sequencer stands
  function automatic i2cram_pkg::item_t random_tick();
    i2cram_pkg::item_t it;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (sb.idle()) begin
      if (pick < 4) it.operation = i2cram_pkg::OP_WRITE;
      else if (pick < 8) it.operation = i2cram_pkg::OP_READ;
      else it.operation = (pick == 8) ? i2cram_pkg::OP_TICK : OP_UNUSED;
    end else begin
      // mostly plain ticks, sometimes a command that must be ignored
      it.operation = (pick < 7) ? i2cram_pkg::OP_TICK : 2'($urandom_range(0, 3));
    end
    it.register_address = 8'($urandom);
    it.write_data       = 8'($urandom);
    if (sb.ack_next()) it.sda_in = ($urandom_range(0, 99) < 12);
    else it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // One tick transfer on the input channel, after a random gap
  task automatic send_tick(i2cram_pkg::item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    operation_i        <= it.operation;
    register_address_i <= it.register_address;
    write_data_i       <= it.write_data;
    sda_in_i           <= it.sda_in;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_tick(it);
  endtask

  task automatic apb_xfer(input logic wr, input logic [i2cram_pkg::APB_ADDR_W-1:0] addr,
                          input logic [i2cram_pkg::APB_DATA_W-1:0] wdata,
                          output logic [i2cram_pkg::APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the device address, then read it back
  task automatic set_device_address(input logic [6:0] addr7);
    logic [i2cram_pkg::APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, DEV_ADDR_OFS, i2cram_pkg::APB_DATA_W'(addr7), rd);
    sb.dev_addr = addr7;
    apb_xfer(1'b0, DEV_ADDR_OFS, '0, rd);
    if (rd !== i2cram_pkg::APB_DATA_W'(addr7))
      sb.report_mismatch($sformatf("device_address read %0h expected %0h", rd, addr7));
  endtask

  // Wait until every predicted result has come back and been checked
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_pin_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall per result, one long hold-off
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned         hold;
    int unsigned         taken;
    i2cram_pkg::result_t got;
    out_stall_i <= 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{scl_level_o, sda_level_o, sda_drive_o, busy_res_o, done_res_o,
              status_o, read_value_o};
      sb.check_result(got);
      taken++;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0]  addr_plan [6];
    int unsigned sent;
    sb = new();
    sb.reset_state();
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    operation_i        <= i2cram_pkg::OP_TICK;
    register_address_i <= 8'h00;
    write_data_i       <= 8'h00;
    sda_in_i           <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    addr_plan[0] = 7'h00;
    addr_plan[1] = 7'h7F;
    addr_plan[2] = 7'h2A;
    addr_plan[3] = 7'h00;
    addr_plan[4] = 7'h55;
    addr_plan[5] = 7'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle ticks with field extremes, unused code, then commands while busy
    send_tick(tick_item(i2cram_pkg::OP_TICK, 8'h00, 8'h00, 1'b0));
    send_tick(tick_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1));
    send_tick(tick_item(i2cram_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1));
    send_tick(tick_item(OP_UNUSED, 8'h00, 8'h00, 1'b0));
    send_tick(tick_item(i2cram_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0));
    send_tick(tick_item(i2cram_pkg::OP_READ, 8'h00, 8'hFF, 1'b1));
    send_tick(tick_item(i2cram_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b0));
    send_tick(tick_item(OP_UNUSED, 8'hFF, 8'h00, 1'b1));

    // random phases, one device address each; phase 0 keeps the reset value
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_results();
        set_device_address(addr_plan[p]);
      end
      no_idle = (p == 3);
      sent = 0;
      while (sent < PHASE_TICKS || !sb.idle()) begin
        send_tick(random_tick());
        sent++;
      end
    end
    no_idle = 1'b0;

    // wind down
    in_valid_i <= 1'b0;
    while (sb.pending_pin_states.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d ticks under six device addresses, %0d results checked",
             sb.ticks_noted, sb.results_checked);
    $display("transfers ended ok %0d, nack devw %0d, reg %0d, data %0d, devr %0d",
             sb.done_by_status[i2cram_pkg::ST_OK], sb.done_by_status[i2cram_pkg::ST_NACK_DEVW],
             sb.done_by_status[i2cram_pkg::ST_NACK_REG],
             sb.done_by_status[i2cram_pkg::ST_NACK_DATA],
             sb.done_by_status[i2cram_pkg::ST_NACK_DEVR]);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
